/* design/twtl_pkg.sv */
// ----------------------------------------------------------------------------
// twtl_pkg
// Shared types, constants and helper functions of the two-way traffic light
// controller with edit mode.
// ----------------------------------------------------------------------------
package twtl_pkg;

    localparam int unsigned SEC_W   = 7;
    localparam int unsigned TPS_W   = 10;
    localparam int unsigned TICKS_W = 17;
    localparam int unsigned COL_W   = 2;

    localparam logic [SEC_W-1:0] SECONDS_MAX     = 7'd99;
    localparam logic [SEC_W-1:0] RED_SECS_RST    = 7'd5;
    localparam logic [SEC_W-1:0] GREEN_SECS_RST  = 7'd3;
    localparam logic [SEC_W-1:0] YELLOW_SECS_RST = 7'd2;
    localparam logic [TPS_W-1:0] TPS_RST         = 10'd20;

    typedef enum logic [2:0] {
        PH_INIT      = 3'd0,
        PH_RG        = 3'd1,
        PH_RY        = 3'd2,
        PH_GR        = 3'd3,
        PH_YR        = 3'd4,
        PH_ED_RED    = 3'd5,
        PH_ED_GREEN  = 3'd6,
        PH_ED_YELLOW = 3'd7
    } phase_t;

    localparam logic [COL_W-1:0] COL_RED    = 2'd0;
    localparam logic [COL_W-1:0] COL_YELLOW = 2'd1;
    localparam logic [COL_W-1:0] COL_GREEN  = 2'd2;
    localparam logic [COL_W-1:0] COL_NONE   = 2'd3;

    typedef struct packed {
        logic manual;
        logic to_green;
        logic to_yellow;
        logic to_auto;
        logic inc;
    } btn_t;

    typedef struct packed {
        phase_t           phase;
        logic [COL_W-1:0] light_one;
        logic [COL_W-1:0] light_two;
        logic [SEC_W-1:0] shown_seconds;
    } result_t;

    // Edited durations wrap to zero at the top of the display range.
    function automatic logic [SEC_W-1:0] bump_secs(input logic [SEC_W-1:0] s);
        logic [SEC_W-1:0] r;
        r = (s >= SECONDS_MAX) ? '0 : s + 7'd1;
        return r;
    endfunction

    function automatic logic [COL_W-1:0] light_one_of(input phase_t p);
        logic [COL_W-1:0] c;
        case (p)
            PH_RG, PH_RY, PH_ED_RED: c = COL_RED;
            PH_GR, PH_ED_GREEN:      c = COL_GREEN;
            PH_YR, PH_ED_YELLOW:     c = COL_YELLOW;
            default:                 c = COL_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [COL_W-1:0] light_two_of(input phase_t p);
        logic [COL_W-1:0] c;
        case (p)
            PH_RG, PH_ED_GREEN:         c = COL_GREEN;
            PH_RY, PH_ED_YELLOW:        c = COL_YELLOW;
            PH_GR, PH_YR, PH_ED_RED:    c = COL_RED;
            default:                    c = COL_NONE;
        endcase
        return c;
    endfunction

endpackage

/* design/twtl_core.sv */
// ----------------------------------------------------------------------------
// twtl_core
// Controller state, phase timer and edit logic. One tick is applied per
// step; the result for that tick is formed combinationally from the
// updated state.
// ----------------------------------------------------------------------------
module twtl_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  twtl_pkg::btn_t               btn,
    input  logic [twtl_pkg::TPS_W-1:0]   tps,
    output twtl_pkg::result_t            result
);
    import twtl_pkg::*;

    phase_t             phase_reg, phase_next, phase_mid;
    logic [SEC_W-1:0]   red_reg, red_next;
    logic [SEC_W-1:0]   green_reg, green_next;
    logic [SEC_W-1:0]   yellow_reg, yellow_next;
    logic [TICKS_W-1:0] ticks_left_reg, ticks_left_next;
    logic               expired_reg, expired_next;

    logic [TICKS_W-1:0] ticks_cnt;
    logic               expired_cnt;
    logic               load_en;
    logic               load_yellow;
    logic [SEC_W-1:0]   load_secs;
    logic [TICKS_W-1:0] load_ticks;
    logic [SEC_W-1:0]   shown;

    // Timer counts first, then the automatic step, then the edit step.
    always_comb
    begin
        ticks_cnt   = (ticks_left_reg != '0) ? ticks_left_reg - 17'd1 : ticks_left_reg;
        expired_cnt = expired_reg | (ticks_left_reg == 17'd1);

        phase_mid   = phase_reg;
        load_en     = 1'b0;
        load_yellow = 1'b0;
        case (phase_reg)
            PH_INIT:
            begin
                load_en   = 1'b1;
                phase_mid = PH_RG;
            end
            PH_RG, PH_RY, PH_GR, PH_YR:
            begin
                // The manual button takes priority over expiry.
                if (btn.manual)
                begin
                    phase_mid = PH_ED_RED;
                end
                else if (expired_cnt)
                begin
                    load_en = 1'b1;
                    case (phase_reg)
                        PH_RG:
                        begin
                            load_yellow = 1'b1;
                            phase_mid   = PH_RY;
                        end
                        PH_RY:   phase_mid = PH_GR;
                        PH_GR:
                        begin
                            load_yellow = 1'b1;
                            phase_mid   = PH_YR;
                        end
                        default: phase_mid = PH_RG;
                    endcase
                end
            end
            default: phase_mid = phase_reg;
        endcase

        load_secs  = load_yellow ? yellow_reg : green_reg;
        load_ticks = {{(TICKS_W-SEC_W){1'b0}}, load_secs} * {{(TICKS_W-TPS_W){1'b0}}, tps};

        ticks_left_next = load_en ? load_ticks : ticks_cnt;
        expired_next    = load_en ? (load_ticks == '0) : expired_cnt;

        phase_next  = phase_mid;
        red_next    = red_reg;
        green_next  = green_reg;
        yellow_next = yellow_reg;
        case (phase_mid)
            PH_ED_RED:
            begin
                if (btn.to_green)
                    phase_next = PH_ED_GREEN;
                if (btn.inc)
                    red_next = bump_secs(red_reg);
            end
            PH_ED_GREEN:
            begin
                if (btn.to_yellow)
                    phase_next = PH_ED_YELLOW;
                if (btn.inc)
                    green_next = bump_secs(green_reg);
            end
            PH_ED_YELLOW:
            begin
                if (btn.to_auto)
                    phase_next = PH_INIT;
                if (btn.inc)
                    yellow_next = bump_secs(yellow_reg);
            end
            default: phase_next = phase_mid;
        endcase
    end

    // Result of the tick, seen after the whole update.
    always_comb
    begin
        case (phase_next)
            PH_RG, PH_ED_GREEN:            shown = green_next;
            PH_RY, PH_ED_YELLOW:           shown = yellow_next;
            PH_GR, PH_YR, PH_ED_RED:       shown = red_next;
            default:                       shown = '0;
        endcase
        result.phase         = phase_next;
        result.light_one     = light_one_of(phase_next);
        result.light_two     = light_two_of(phase_next);
        result.shown_seconds = shown;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_INIT;
            red_reg        <= RED_SECS_RST;
            green_reg      <= GREEN_SECS_RST;
            yellow_reg     <= YELLOW_SECS_RST;
            ticks_left_reg <= '0;
            expired_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            yellow_reg     <= yellow_next;
            ticks_left_reg <= ticks_left_next;
            expired_reg    <= expired_next;
        end
    end

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(ticks_left_reg))
        else $error("controller state changed without a tick");

    a_init_to_rg: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_INIT) |=> phase_reg == PH_RG)
        else $error("init phase did not move to red/green");

    a_red_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_mid == PH_ED_RED && btn.inc && red_reg == SECONDS_MAX)
        |=> red_reg == '0)
        else $error("red duration did not wrap to zero");

endmodule

/* design/two_way_traffic_light_with_edit_mode_unit.sv */
// ----------------------------------------------------------------------------
// two_way_traffic_light_with_edit_mode_unit
// Two-way traffic light controller with a duration edit mode.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer (in_valid high, in_stall low) is one timebase tick with
// five button-press pulses. Every tick produces exactly one output transfer
// (out_valid high, out_stall low) carrying the phase, both light colours and
// the duration shown for that phase.
// The tick is captured in an input register and then applied to the
// controller state; the result lands in the output register. One tick is
// accepted every cycle while the output side takes results.
// When the receiver stalls, the output register holds its result, the input
// register fills and in_stall rises; no tick is lost or applied twice.
// The ticks_per_second register is written through cfg_valid/cfg_data
// (cfg_ready is always high) and takes effect at the next timer load.
// Reset puts the controller in its init phase with durations red 5, green 3,
// yellow 2 seconds, ticks_per_second 20 and both pipeline registers empty.
// ----------------------------------------------------------------------------
module two_way_traffic_light_with_edit_mode_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         btn_manual,
    input  logic                         btn_to_green_edit,
    input  logic                         btn_to_yellow_edit,
    input  logic                         btn_back_to_auto,
    input  logic                         btn_increment,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   phase,
    output logic [twtl_pkg::COL_W-1:0]   light_one,
    output logic [twtl_pkg::COL_W-1:0]   light_two,
    output logic [twtl_pkg::SEC_W-1:0]   shown_seconds,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [twtl_pkg::TPS_W-1:0]   cfg_data
);
    import twtl_pkg::*;

    logic             s1_valid_reg;
    btn_t             s1_btn_reg;
    logic             out_valid_reg;
    result_t          out_result_reg;
    logic [TPS_W-1:0] tps_reg;

    logic    out_free;
    logic    step;
    logic    in_take;
    result_t core_result;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    twtl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .btn    (s1_btn_reg),
        .tps    (tps_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tps_reg       <= TPS_RST;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (cfg_valid && cfg_ready)
                tps_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_btn_reg.manual    <= btn_manual;
            s1_btn_reg.to_green  <= btn_to_green_edit;
            s1_btn_reg.to_yellow <= btn_to_yellow_edit;
            s1_btn_reg.to_auto   <= btn_back_to_auto;
            s1_btn_reg.inc       <= btn_increment;
        end
        if (step)
            out_result_reg <= core_result;
    end

    assign out_valid     = out_valid_reg;
    assign phase         = out_result_reg.phase;
    assign light_one     = out_result_reg.light_one;
    assign light_two     = out_result_reg.light_two;
    assign shown_seconds = out_result_reg.shown_seconds;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted tick not held in the input register");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("applied tick produced no result");

endmodule

/* tb/sv/tb_two_way_traffic_light_with_edit_mode_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_way_traffic_light_with_edit_mode_unit
// Self-checking bench for the two-way traffic light controller. A model of
// the phase sequencer, its timer and its edit modes is kept in step with
// every accepted tick. Each result transfer is compared with the oldest
// expected result. Directed walks cover the automatic cycle, the edit modes,
// manual entry at timer expiry, zero-length phases and back-pressure. Random
// edit sessions, automatic stretches and button noise follow under several
// tick rates and idling mixes.
// ----------------------------------------------------------------------------
module tb_two_way_traffic_light_with_edit_mode_unit;

    import twtl_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int SHOW_LIMIT  = 10;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                btn_manual;
    logic                btn_to_green_edit;
    logic                btn_to_yellow_edit;
    logic                btn_back_to_auto;
    logic                btn_increment;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          phase;
    logic [COL_W-1:0]    light_one;
    logic [COL_W-1:0]    light_two;
    logic [SEC_W-1:0]    shown_seconds;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TPS_W-1:0]    cfg_data;

    two_way_traffic_light_with_edit_mode_unit u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .btn_manual         (btn_manual),
        .btn_to_green_edit  (btn_to_green_edit),
        .btn_to_yellow_edit (btn_to_yellow_edit),
        .btn_back_to_auto   (btn_back_to_auto),
        .btn_increment      (btn_increment),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .phase              (phase),
        .light_one          (light_one),
        .light_two          (light_two),
        .shown_seconds      (shown_seconds),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    // Controller model state.
    phase_t             ctl_phase   = PH_INIT;
    logic [SEC_W-1:0]   red_secs    = RED_SECS_RST;
    logic [SEC_W-1:0]   green_secs  = GREEN_SECS_RST;
    logic [SEC_W-1:0]   yellow_secs = YELLOW_SECS_RST;
    logic [TICKS_W-1:0] timer_ticks = '0;
    logic               timer_done  = 1'b0;
    logic [TPS_W-1:0]   tick_rate   = TPS_RST;

    result_t lamp_q[$];
    int      ticks_sent    = 0;
    int      errors        = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    bit      hold_req      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void load_timer(input logic [SEC_W-1:0] secs);
        int unsigned product;
        product     = secs * tick_rate;
        timer_ticks = TICKS_W'(product);
        timer_done  = (timer_ticks == '0);
    endfunction

    function automatic logic [SEC_W-1:0] next_secs(input logic [SEC_W-1:0] s);
        return (s >= SECONDS_MAX) ? '0 : s + 7'd1;
    endfunction

    // Advances the model by one tick and returns the lamp state after it.
    function automatic result_t predict_tick(input btn_t b);
        result_t r;
        if (timer_ticks != '0)
        begin
            timer_ticks = timer_ticks - 1'b1;
            if (timer_ticks == '0)
                timer_done = 1'b1;
        end
        case (ctl_phase)
            PH_INIT:
            begin
                load_timer(green_secs);
                ctl_phase = PH_RG;
            end
            PH_RG, PH_RY, PH_GR, PH_YR:
            begin
                // The manual button takes priority over an expiring timer.
                if (b.manual)
                    ctl_phase = PH_ED_RED;
                else if (timer_done)
                begin
                    case (ctl_phase)
                        PH_RG:
                        begin
                            load_timer(yellow_secs);
                            ctl_phase = PH_RY;
                        end
                        PH_RY:
                        begin
                            load_timer(green_secs);
                            ctl_phase = PH_GR;
                        end
                        PH_GR:
                        begin
                            load_timer(yellow_secs);
                            ctl_phase = PH_YR;
                        end
                        default:
                        begin
                            load_timer(green_secs);
                            ctl_phase = PH_RG;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        // A phase entered above still sees this tick's edit buttons.
        case (ctl_phase)
            PH_ED_RED:
            begin
                if (b.to_green)
                    ctl_phase = PH_ED_GREEN;
                if (b.inc)
                    red_secs = next_secs(red_secs);
            end
            PH_ED_GREEN:
            begin
                if (b.to_yellow)
                    ctl_phase = PH_ED_YELLOW;
                if (b.inc)
                    green_secs = next_secs(green_secs);
            end
            PH_ED_YELLOW:
            begin
                if (b.to_auto)
                    ctl_phase = PH_INIT;
                if (b.inc)
                    yellow_secs = next_secs(yellow_secs);
            end
            default: ;
        endcase
        r.phase = ctl_phase;
        case (ctl_phase)
            PH_RG:        begin r.light_one = COL_RED;    r.light_two = COL_GREEN;
                                r.shown_seconds = green_secs;  end
            PH_RY:        begin r.light_one = COL_RED;    r.light_two = COL_YELLOW;
                                r.shown_seconds = yellow_secs; end
            PH_GR:        begin r.light_one = COL_GREEN;  r.light_two = COL_RED;
                                r.shown_seconds = red_secs;    end
            PH_YR:        begin r.light_one = COL_YELLOW; r.light_two = COL_RED;
                                r.shown_seconds = red_secs;    end
            PH_ED_RED:    begin r.light_one = COL_RED;    r.light_two = COL_RED;
                                r.shown_seconds = red_secs;    end
            PH_ED_GREEN:  begin r.light_one = COL_GREEN;  r.light_two = COL_GREEN;
                                r.shown_seconds = green_secs;  end
            PH_ED_YELLOW: begin r.light_one = COL_YELLOW; r.light_two = COL_YELLOW;
                                r.shown_seconds = yellow_secs; end
            default:      begin r.light_one = COL_NONE;   r.light_two = COL_NONE;
                                r.shown_seconds = '0;          end
        endcase
        return r;
    endfunction

    function automatic btn_t press(input int m, input int g, input int y,
                                   input int a, input int i);
        return btn_t'({m != 0, g != 0, y != 0, a != 0, i != 0});
    endfunction

    function automatic btn_t noise_buttons();
        return btn_t'(5'($urandom & $urandom));
    endfunction

    // Offers one tick and returns at the edge where it is transferred.
    task automatic send_tick(input btn_t b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid           = 1'b1;
        btn_manual         = b.manual;
        btn_to_green_edit  = b.to_green;
        btn_to_yellow_edit = b.to_yellow;
        btn_back_to_auto   = b.to_auto;
        btn_increment      = b.inc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lamp_q.push_back(predict_tick(b));
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every result has been taken.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (lamp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = rate;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tick_rate = rate;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_automatic_cycle();
        write_tick_rate(10'd1);
        repeat (11) send_tick(press(0, 0, 0, 0, 0));
    endtask

    task automatic test_edit_walk();
        send_tick(press(1, 0, 0, 0, 1));
        send_tick(press(0, 0, 1, 1, 1));
        send_tick(press(1, 1, 1, 0, 1));
        send_tick(press(0, 1, 1, 1, 1));
        send_tick(press(0, 0, 0, 1, 1));
    endtask

    task automatic test_manual_beats_expiry();
        int guard;
        guard = 0;
        while (!(ctl_phase >= PH_RG && ctl_phase <= PH_YR && timer_ticks == 1)
               && guard < 300)
        begin
            send_tick(press(0, 0, 0, 0, 0));
            guard++;
        end
        send_tick(press(1, 0, 0, 0, 0));
        send_tick(press(0, 1, 0, 0, 0));
        send_tick(press(0, 0, 1, 0, 0));
        send_tick(press(0, 0, 0, 1, 0));
    endtask

    // A zero tick rate makes every load expire at once.
    task automatic test_zero_duration();
        settle();
        write_tick_rate(10'd0);
        repeat (5) send_tick(press(0, 0, 0, 0, 0));
    endtask

    task automatic test_back_pressure();
        settle();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_tick_rate(10'd1000);
        @(posedge clk);
        hold_req = 1'b1;
        repeat (30) send_tick(noise_buttons());
    endtask

    task automatic edit_session();
        btn_t b;
        int   n_inc;
        send_tick(press(1, $urandom_range(0, 1), 0, 0, $urandom_range(0, 1)));
        for (int stage = 0; stage < 3; stage++)
        begin
            n_inc = ($urandom_range(0, 11) == 0) ? $urandom_range(90, 110)
                                                 : $urandom_range(0, 8);
            repeat (n_inc)
            begin
                b     = noise_buttons();
                b.inc = ($urandom_range(0, 3) != 0);
                case (stage)
                    0:       b.to_green  = 1'b0;
                    1:       b.to_yellow = 1'b0;
                    default: b.to_auto   = 1'b0;
                endcase
                send_tick(b);
            end
            b = noise_buttons();
            case (stage)
                0:       b.to_green  = 1'b1;
                1:       b.to_yellow = 1'b1;
                default: b.to_auto   = 1'b1;
            endcase
            send_tick(b);
            // Now and then a session is abandoned half way.
            if ($urandom_range(0, 15) == 0)
                break;
        end
    endtask

    task automatic test_random_traffic(input logic [TPS_W-1:0] rate, input int idle_pct,
                                       input int hold_pct, input int n_items);
        int   first;
        int   pick;
        btn_t b;
        settle();
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        write_tick_rate(rate);
        first = ticks_sent;
        while (ticks_sent - first < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                edit_session();
            else if (pick < 8)
            begin
                repeat ($urandom_range(1, 40))
                begin
                    b        = noise_buttons();
                    b.manual = ($urandom_range(0, 39) == 0);
                    send_tick(b);
                end
            end
            else
                repeat ($urandom_range(1, 10)) send_tick(btn_t'(5'($urandom)));
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lamp_q.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: result transfer with nothing expected: phase %0d",
                             $realtime, phase);
            end
            else
            begin
                want = lamp_q.pop_front();
                if (phase !== want.phase || light_one !== want.light_one ||
                    light_two !== want.light_two ||
                    shown_seconds !== want.shown_seconds)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display({"%0t: mismatch: expected phase %0d lights %0d/%0d ",
                                  "seconds %0d, got phase %0d lights %0d/%0d seconds %0d"},
                                 $realtime, want.phase, want.light_one, want.light_two,
                                 want.shown_seconds, phase, light_one, light_two,
                                 shown_seconds);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        btn_manual         = 1'b0;
        btn_to_green_edit  = 1'b0;
        btn_to_yellow_edit = 1'b0;
        btn_back_to_auto   = 1'b0;
        btn_increment      = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_automatic_cycle();
        test_edit_walk();
        test_manual_beats_expiry();
        test_zero_duration();
        test_back_pressure();
        test_random_traffic(10'd1, 0, 0, 480);
        test_random_traffic(10'd2, 46, 0, 480);
        test_random_traffic(10'd1000, 0, 46, 480);
        test_random_traffic(10'($urandom_range(1, 8)), 16, 16, 480);
        settle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* two_way_traffic_light_with_edit_mode_unit.f */
design/twtl_pkg.sv
design/twtl_core.sv
design/two_way_traffic_light_with_edit_mode_unit.sv
tb/sv/tb_two_way_traffic_light_with_edit_mode_unit.sv
